// ----- rtl/core/b2da_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; used by binary_to_decimal_ascii.
package b2da_pkg;

  // default width of the binary input
  localparam int DEF_VALUE_BITS = 32;

  // log10(2) scaled by LOG2_DEN, used to size the digit register
  localparam int LOG2_NUM = 30103;
  localparam int LOG2_DEN = 100000;

  // character codes
  localparam logic [5:0] DIGIT_BASE = 6'd48;
  localparam logic [5:0] TERMINATOR = 6'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_TERM
  } state_t;

  // datapath controls decoded from the state
  typedef struct packed {
    logic load;        // take a new value
    logic shift_bit;   // one double-dabble step
    logic skip_digit;  // drop a leading zero digit
    logic emit_digit;  // send the top digit
    logic emit_term;   // send the terminator
  } ctrl_t;

endpackage

// ----- rtl/core/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter, bit-serial double dabble.
// Sequence: value accepted, shifted in one bit per cycle through the double
// dabble loop, then the BCD digits most significant first (leading zeros dropped,
// at least one digit kept), at most one digit per cycle and held while the output
// stalls, then the terminator. A new value is taken only in idle, once the
// terminator of the previous value has been sent.
// Reset: synchronous, returns to idle and empties the output register.
module binary_to_decimal_ascii #(
  parameter int VALUE_BITS = b2da_pkg::DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [5:0]            char_code,
  output logic                  last
);
  import b2da_pkg::*;

  localparam int DIGITS = (VALUE_BITS * LOG2_NUM) / LOG2_DEN + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int BCNT_W = $clog2(VALUE_BITS + 1);
  localparam int DCNT_W = $clog2(DIGITS + 1);

  state_t state, state_next;
  ctrl_t  ctrl;

  logic [VALUE_BITS-1:0] bin_sr;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BCNT_W-1:0]     bit_cnt;
  logic [DCNT_W-1:0]     dig_cnt;
  logic                  leading;
  logic [3:0]            top_nib;
  logic                  out_free;
  logic                  skip_ok;

  assign top_nib  = bcd[BCD_W-1 -: 4];
  assign out_free = !out_valid || !out_stall;
  assign skip_ok  = leading && (top_nib == 4'd0) && (dig_cnt > DCNT_W'(1));
  assign in_stall = (state != ST_IDLE);

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt == BCNT_W'(1)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!skip_ok && out_free && dig_cnt == DCNT_W'(1)) state_next = ST_TERM;
      end
      ST_TERM: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE: ctrl.load       = in_valid;
      ST_CONV: ctrl.shift_bit  = 1'b1;
      ST_EMIT: begin
        ctrl.skip_digit = skip_ok;
        ctrl.emit_digit = !skip_ok && out_free;
      end
      ST_TERM: ctrl.emit_term  = out_free;
      default: ctrl = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.emit_digit || ctrl.emit_term) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // conversion shift registers and counters
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin_sr  <= value;
      bcd     <= '0;
      bit_cnt <= BCNT_W'(VALUE_BITS);
      dig_cnt <= DCNT_W'(DIGITS);
      leading <= 1'b1;
    end else if (ctrl.shift_bit) begin
      bcd     <= {bcd_adj[BCD_W-2:0], bin_sr[VALUE_BITS-1]};
      bin_sr  <= {bin_sr[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - BCNT_W'(1);
    end else if (ctrl.skip_digit || ctrl.emit_digit) begin
      bcd     <= {bcd[BCD_W-5:0], 4'd0};
      dig_cnt <= dig_cnt - DCNT_W'(1);
      if (ctrl.emit_digit) leading <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.emit_digit) begin
      char_code <= DIGIT_BASE + {2'b00, top_nib};
      last      <= 1'b0;
    end else if (ctrl.emit_term) begin
      char_code <= TERMINATOR;
      last      <= 1'b1;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for binary_to_decimal_ascii: drives numbers, predicts the
// decimal character stream and compares every character transfer in order.
// Depends on b2da_pkg and binary_to_decimal_ascii; nothing else.
module tb_top;
  import b2da_pkg::*;

  localparam int NUM_BITS    = 32;
  localparam int RANDOM_NUMS = 320;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 120;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    bit                  drain;  // pause until the block has emptied
    logic [NUM_BITS-1:0] num;
  } num_req_t;

  typedef struct {
    logic [5:0] code;
    logic       lst;
  } char_exp_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [NUM_BITS-1:0] value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [5:0]          char_code;
  logic                last;

  num_req_t  num_reqs[$];
  char_exp_t expected_chars[$];

  int n_offered   = 0;
  int n_in_acc    = 0;
  int n_chars     = 0;
  int n_lasts     = 0;
  int n_mismatch  = 0;
  int n_cycles    = 0;
  int n_directed  = 0;
  int burst_left  = 1;
  int gap_left    = 0;
  int stall_left  = 0;
  int stall_mode  = 0;
  int hold_left   = 0;
  int holds_done  = 0;

  binary_to_decimal_ascii #(.VALUE_BITS(NUM_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

  always #6 clk = ~clk;

  // expected digit characters, most significant first, then the terminator
  function automatic void predict_decimal_chars(input logic [NUM_BITS-1:0] num);
    logic [NUM_BITS-1:0] rest;
    logic [5:0]          digs[0:19];
    int                  count;
    rest  = num;
    count = 0;
    do begin
      digs[count] = DIGIT_BASE + 6'(rest % 10);
      rest = rest / 10;
      count++;
    end while (rest != 0);
    for (int k = count - 1; k >= 0; k--) begin
      expected_chars.push_back('{code: digs[k], lst: 1'b0});
    end
    expected_chars.push_back('{code: TERMINATOR, lst: 1'b1});
  endfunction

  // random number with a random magnitude so every digit count shows up
  function automatic logic [NUM_BITS-1:0] random_num();
    int nbits;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    nbits = $urandom_range(1, NUM_BITS);
    return $urandom & ({NUM_BITS{1'b1}} >> (NUM_BITS - nbits));
  endfunction

  task automatic add_num(input logic [NUM_BITS-1:0] num);
    num_reqs.push_back('{drain: 1'b0, num: num});
  endtask

  task automatic add_drain();
    num_reqs.push_back('{drain: 1'b1, num: '0});
  endtask

  // input driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    num_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      value    <= '0;
    end else if (in_valid && n_in_acc != n_offered) begin
      // offered but not yet taken: hold steady
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      value    <= $urandom;
      gap_left--;
    end else if (num_reqs.size() == 0) begin
      in_valid <= 1'b0;
    end else if (num_reqs[0].drain) begin
      in_valid <= 1'b0;
      if (expected_chars.size() == 0 && n_in_acc == n_offered) begin
        void'(num_reqs.pop_front());
      end
    end else begin
      req = num_reqs.pop_front();
      in_valid <= 1'b1;
      value    <= req.num;
      n_offered++;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      end
    end
  end

  // output stall pattern, with two long hold-offs while the sender keeps going
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if ((holds_done == 0 && n_in_acc >= 60) ||
                 (holds_done == 1 && n_in_acc >= 220)) begin
      out_stall <= 1'b1;
      hold_left = $urandom_range(300, 500);
      holds_done++;
    end else begin
      if (stall_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= ~out_stall;
        end
      endcase
    end
  end

  // predict on each input transfer, check each character transfer
  always @(posedge clk) begin
    char_exp_t exp_c;
    if (!rst && in_valid && !in_stall) begin
      predict_decimal_chars(value);
      n_in_acc++;
    end
    if (!rst && out_valid && !out_stall) begin
      n_chars++;
      if (last) begin
        n_lasts++;
      end
      if (expected_chars.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= REPORT_MAX) begin
          $display("unexpected character transfer: char_code=%0d last=%0b", char_code, last);
        end
      end else begin
        exp_c = expected_chars.pop_front();
        if (char_code !== exp_c.code || last !== exp_c.lst) begin
          n_mismatch++;
          if (n_mismatch <= REPORT_MAX) begin
            $display("mismatch at char %0d: expected char_code=%0d last=%0b, got %0d %0b",
                     n_chars, exp_c.code, exp_c.lst, char_code, last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               n_cycles, expected_chars.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    // directed: extremes, zero, digit-count boundaries
    add_num(32'd0);
    add_num(32'd1);
    add_num(32'd9);
    add_num(32'd10);
    add_num(32'd99);
    add_num(32'd100);
    add_num(32'd0);
    add_num(32'd7);
    add_num(32'd12345);
    add_num(32'd65535);
    add_num(32'd999999999);
    add_num(32'd1000000000);
    add_num(32'd1234567890);
    add_num(32'd2147483647);
    add_num(32'd2147483648);
    add_num(32'd3999999999);
    add_num(32'd4000000000);
    add_num(32'd4294967294);
    add_num(32'd4294967295);
    add_num(32'hAAAAAAAA);
    add_num(32'h55555555);
    n_directed = 21;
    add_drain();
    // random numbers, with a few full drains along the way
    for (int i = 0; i < RANDOM_NUMS; i++) begin
      add_num(random_num());
      if (i % 80 == 79) begin
        add_drain();
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
    end while (num_reqs.size() != 0 || n_in_acc != n_offered || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("converted %0d numbers (%0d directed, zero and 32-bit extremes included)",
             n_in_acc, n_directed);
    $display("checked %0d characters in %0d strings, %0d mismatches, %0d cycles",
             n_chars, n_lasts, n_mismatch, n_cycles);
    if (n_mismatch == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/b2da_pkg.sv
rtl/core/binary_to_decimal_ascii.sv
tb/sv/tb_top.sv
